FILE: rtl/mbsp_pkg.sv
// Shared types and codes for the MIDI byte stream parser.
// No dependencies; used by mbsp_decode and midi_byte_stream_parser.
package mbsp_pkg;

  localparam int unsigned FilterWidth = 5;

  // Status byte groups (high nibble for channel messages, whole byte for system)
  localparam logic [7:0] GRP_NOTE_OFF  = 8'h80;
  localparam logic [7:0] GRP_NOTE_ON   = 8'h90;
  localparam logic [7:0] GRP_POLY_PRES = 8'ha0;
  localparam logic [7:0] GRP_CTRL      = 8'hb0;
  localparam logic [7:0] GRP_PROGRAM   = 8'hc0;
  localparam logic [7:0] GRP_CHAN_PRES = 8'hd0;
  localparam logic [7:0] GRP_PITCH     = 8'he0;
  localparam logic [7:0] GRP_SYS       = 8'hf0;
  localparam logic [7:0] SYS_EX_START  = 8'hf0;
  localparam logic [7:0] SYS_SONG_POS  = 8'hf2;
  localparam logic [7:0] SYS_SONG_SEL  = 8'hf3;
  localparam logic [7:0] SYS_TUNE      = 8'hf6;
  localparam logic [7:0] SYS_EX_END    = 8'hf7;
  localparam logic [7:0] RT_CLOCK      = 8'hf8;
  localparam logic [7:0] RT_START      = 8'hfa;
  localparam logic [7:0] RT_CONTINUE   = 8'hfb;
  localparam logic [7:0] RT_STOP       = 8'hfc;
  localparam logic [7:0] RT_SENSE      = 8'hfe;
  localparam logic [7:0] RT_RESET      = 8'hff;

  typedef enum logic [4:0] {
    KIND_NOTE_OFF  = 5'd0,
    KIND_NOTE_ON   = 5'd1,
    KIND_POLY_PRES = 5'd2,
    KIND_CTRL      = 5'd3,
    KIND_PROGRAM   = 5'd4,
    KIND_CHAN_PRES = 5'd5,
    KIND_PITCH     = 5'd6,
    KIND_SONG_POS  = 5'd7,
    KIND_SONG_SEL  = 5'd8,
    KIND_TUNE      = 5'd9,
    KIND_CLOCK     = 5'd10,
    KIND_START     = 5'd11,
    KIND_CONTINUE  = 5'd12,
    KIND_STOP      = 5'd13,
    KIND_SENSE     = 5'd14,
    KIND_RESET     = 5'd15,
    KIND_SYS_START = 5'd16,
    KIND_SYS_END   = 5'd17,
    KIND_SYS_BYTE  = 5'd18
  } kind_t;

  typedef struct packed {
    logic       in_sysex;
    logic [7:0] running_status;
    logic [1:0] bytes_needed;
    logic [1:0] bytes_received;
    logic [6:0] held_data;
  } parse_state_t;

  typedef struct packed {
    kind_t       event_kind;
    logic [4:0]  channel_number;
    logic [6:0]  first_value;
    logic [6:0]  second_value;
    logic [13:0] wide_value;
    logic [7:0]  raw_byte;
  } midi_event_t;

endpackage

FILE: rtl/mbsp_decode.sv
// Combinational decode of one received byte against the parser state.
// Produces the next state and, when a message completes, the event.
// Depends on mbsp_pkg.
module mbsp_decode (
  input  logic [7:0]                       rx_byte,
  input  logic [mbsp_pkg::FilterWidth-1:0] channel_filter,
  input  mbsp_pkg::parse_state_t           state,
  output mbsp_pkg::parse_state_t           state_nxt,
  output logic                             emit,
  output mbsp_pkg::midi_event_t            evt
);
  import mbsp_pkg::*;

  logic [7:0] group;
  logic [7:0] rs_group;
  logic [4:0] chan;
  logic [1:0] rcv_inc;
  logic       pass;

  assign group    = (rx_byte < GRP_SYS) ? (rx_byte & 8'hf0) : rx_byte;
  assign rs_group = (state.running_status < GRP_SYS) ?
                    (state.running_status & 8'hf0) : state.running_status;
  assign chan     = {1'b0, state.running_status[3:0]} + 5'd1;
  assign rcv_inc  = state.bytes_received + 2'd1;
  assign pass     = (channel_filter == '0) || (chan == channel_filter) ||
                    (rs_group >= GRP_SYS);

  always_comb begin
    state_nxt = state;
    emit      = 1'b0;
    evt       = '0;
    priority if (state.in_sysex && rx_byte != SYS_EX_END) begin
      emit           = 1'b1;
      evt.event_kind = KIND_SYS_BYTE;
      evt.raw_byte   = rx_byte;
    end else if (rx_byte[7]) begin
      unique case (group)
        GRP_NOTE_OFF, GRP_NOTE_ON, GRP_POLY_PRES, GRP_CTRL, GRP_PITCH,
        SYS_SONG_POS: begin
          state_nxt.bytes_needed   = 2'd2;
          state_nxt.bytes_received = 2'd0;
          state_nxt.running_status = rx_byte;
        end
        GRP_PROGRAM, GRP_CHAN_PRES, SYS_SONG_SEL: begin
          state_nxt.bytes_needed   = 2'd1;
          state_nxt.bytes_received = 2'd0;
          state_nxt.running_status = rx_byte;
        end
        SYS_EX_START: begin
          state_nxt.in_sysex = 1'b1;
          emit               = 1'b1;
          evt.event_kind     = KIND_SYS_START;
        end
        SYS_EX_END: begin
          state_nxt.in_sysex = 1'b0;
          emit               = 1'b1;
          evt.event_kind     = KIND_SYS_END;
        end
        SYS_TUNE: begin
          emit = 1'b1; evt.event_kind = KIND_TUNE;
        end
        RT_CLOCK: begin
          emit = 1'b1; evt.event_kind = KIND_CLOCK;
        end
        RT_START: begin
          emit = 1'b1; evt.event_kind = KIND_START;
        end
        RT_CONTINUE: begin
          emit = 1'b1; evt.event_kind = KIND_CONTINUE;
        end
        RT_STOP: begin
          emit = 1'b1; evt.event_kind = KIND_STOP;
        end
        RT_SENSE: begin
          emit = 1'b1; evt.event_kind = KIND_SENSE;
        end
        RT_RESET: begin
          emit = 1'b1; evt.event_kind = KIND_RESET;
        end
        default: begin
          // unhandled status: drop, state untouched
        end
      endcase
    end else begin
      state_nxt.held_data = rx_byte[6:0];
      if (state.bytes_needed != 2'd0) begin
        state_nxt.bytes_received = rcv_inc;
        if (rcv_inc == state.bytes_needed) begin
          state_nxt.bytes_received = 2'd0;
          if (pass) begin
            emit               = 1'b1;
            evt.channel_number = chan;
            unique case (rs_group)
              GRP_NOTE_ON: begin
                evt.first_value = state.held_data;
                if (rx_byte[6:0] != 7'd0) begin
                  evt.event_kind   = KIND_NOTE_ON;
                  evt.second_value = rx_byte[6:0];
                end else begin
                  evt.event_kind   = KIND_NOTE_OFF;
                end
              end
              GRP_NOTE_OFF: begin
                evt.event_kind   = KIND_NOTE_OFF;
                evt.first_value  = state.held_data;
                evt.second_value = rx_byte[6:0];
              end
              GRP_POLY_PRES: begin
                evt.event_kind   = KIND_POLY_PRES;
                evt.first_value  = state.held_data;
                evt.second_value = rx_byte[6:0];
              end
              GRP_CTRL: begin
                evt.event_kind   = KIND_CTRL;
                evt.first_value  = state.held_data;
                evt.second_value = rx_byte[6:0];
              end
              GRP_PROGRAM: begin
                evt.event_kind  = KIND_PROGRAM;
                evt.first_value = rx_byte[6:0];
              end
              GRP_CHAN_PRES: begin
                evt.event_kind  = KIND_CHAN_PRES;
                evt.first_value = rx_byte[6:0];
              end
              GRP_PITCH: begin
                evt.event_kind = KIND_PITCH;
                evt.wide_value = {rx_byte[6:0], state.held_data};
              end
              SYS_SONG_POS: begin
                evt.event_kind     = KIND_SONG_POS;
                evt.channel_number = '0;
                evt.wide_value     = {rx_byte[6:0], state.held_data};
              end
              SYS_SONG_SEL: begin
                evt.event_kind     = KIND_SONG_SEL;
                evt.channel_number = '0;
                evt.first_value    = rx_byte[6:0];
              end
              default: begin
                emit = 1'b0;
                evt  = '0;
              end
            endcase
          end
        end
      end
    end
  end

endmodule

FILE: rtl/midi_byte_stream_parser.sv
// MIDI byte stream parser with running status, channel filter and
// system-exclusive pass-through. One byte is accepted per clock while
// in_stall is low; each byte is held in the input register, where it is
// decoded against the parser state, and any resulting message is then
// registered in the output register, which drives out_valid.
// out_stall reaches in_stall through the input register's hold logic in the
// same cycle. channel_filter is written through cfg_ and is always ready.
// Depends on mbsp_pkg and mbsp_decode.
module midi_byte_stream_parser (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_rx_byte,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mbsp_pkg::FilterWidth-1:0] cfg_channel_filter,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [4:0]                       out_event_kind,
  output logic [4:0]                       out_channel_number,
  output logic [6:0]                       out_first_value,
  output logic [6:0]                       out_second_value,
  output logic [13:0]                      out_wide_value,
  output logic [7:0]                       out_raw_byte
);
  import mbsp_pkg::*;

  logic                   in_valid_r;
  logic [7:0]             in_byte_r;
  logic [FilterWidth-1:0] filter_r;
  parse_state_t           state_r;
  parse_state_t           state_nxt;
  logic                   out_valid_r;
  midi_event_t            out_evt_r;
  logic                   emit;
  midi_event_t            evt;
  logic                   out_free;
  logic                   process;

  assign out_free  = !out_valid_r || !out_stall;
  assign process   = in_valid_r && out_free;
  assign in_stall  = in_valid_r && !out_free;
  assign cfg_ready = 1'b1;

  mbsp_decode u_decode (
    .rx_byte        (in_byte_r),
    .channel_filter (filter_r),
    .state          (state_r),
    .state_nxt      (state_nxt),
    .emit           (emit),
    .evt            (evt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
      filter_r    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        filter_r <= cfg_channel_filter;
      end
      // input register: load on accept, empty once decoded
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (process) begin
        state_r <= state_nxt;
      end
      if (out_free) begin
        out_valid_r <= process && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_byte_r <= in_rx_byte;
    end
    if (process && emit) begin
      out_evt_r <= evt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_kind     = out_evt_r.event_kind;
  assign out_channel_number = out_evt_r.channel_number;
  assign out_first_value    = out_evt_r.first_value;
  assign out_second_value   = out_evt_r.second_value;
  assign out_wide_value     = out_evt_r.wide_value;
  assign out_raw_byte       = out_evt_r.raw_byte;

endmodule
